@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------
// assertion macros
// Shared forms for the concurrent checks of the range-minimum block.
// ----------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is skipped while reset is asserted
`define SRMQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds during reset
`define SRMQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/srmq_pkg.sv @@
// ----------------------------------------------------------------------
// srmq_pkg
// Types, sizes and helpers shared by the range-minimum query block.
// ----------------------------------------------------------------------
package srmq_pkg;

  // storage sizes, fixed by the 10-bit position fields
  localparam int MAX_ELEMENTS = 1024;
  localparam int LEVELS       = 11;
  localparam int POS_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int LVL_W        = $clog2(LEVELS);
  localparam int KEY_W        = 16;
  localparam int TAG_W        = 16;
  localparam int ELEM_W       = KEY_W + TAG_W;
  localparam int TBL_DEPTH    = LEVELS * MAX_ELEMENTS;

  // command queue between front and back
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // item kinds
  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_APPEND,
    ST_Q_KEY,
    ST_Q_PICK,
    ST_EMIT
  } back_state_e;

  // classified command handed from front to back
  typedef struct packed {
    kind_e             op;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
    logic [POS_W-1:0]  rpos;
    logic [LVL_W-1:0]  lvl;
  } cmd_t;

  // floor of log2, capped at the top table level
  function automatic logic [LVL_W-1:0] flog2(input logic [CNT_W-1:0] v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (v[i]) r = LVL_W'(i);
    end
    if (r > LVL_W'(LEVELS - 1)) r = LVL_W'(LEVELS - 1);
    return r;
  endfunction

endpackage

@@ rtl/core/srmq_ram.sv @@
// ----------------------------------------------------------------------
// srmq_ram
// Generic RAM, one write port and two read ports with registered data.
// ----------------------------------------------------------------------
module srmq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/core/srmq_front.sv @@
// ----------------------------------------------------------------------
// srmq_front
// Accepts items, drops unused kinds, orders query bounds and works out
// the table level and the second block start of a query.
// ----------------------------------------------------------------------
module srmq_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic [srmq_pkg::KEY_W-1:0]  key_value_i,
  input  logic [srmq_pkg::TAG_W-1:0]  tag_value_i,
  input  logic [srmq_pkg::POS_W-1:0]  lo_index_i,
  input  logic [srmq_pkg::POS_W-1:0]  hi_index_i,
  output logic                        cmd_push_o,
  output srmq_pkg::cmd_t              cmd_o,
  input  logic                        cmd_full_i
);

  logic                        valid_q;
  logic                        valid_d;
  srmq_pkg::cmd_t              cmd_q;
  srmq_pkg::cmd_t              cmd_d;
  logic                        accept;
  logic                        load;
  logic [srmq_pkg::POS_W-1:0]  lo_s;
  logic [srmq_pkg::POS_W-1:0]  hi_s;
  logic [srmq_pkg::CNT_W-1:0]  len;
  logic [srmq_pkg::LVL_W-1:0]  lvl;
  logic [srmq_pkg::CNT_W-1:0]  rpos_full;

  // handshake: hold off while the staged item cannot enter the queue
  assign in_stall_o = valid_q && cmd_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd_push_o = valid_q && !cmd_full_i;
  assign cmd_o      = cmd_q;

  // kind decode, unused kind is taken and dropped
  always_comb begin
    unique case (kind_i)
      srmq_pkg::KIND_CLEAR,
      srmq_pkg::KIND_APPEND,
      srmq_pkg::KIND_QUERY: load = accept;
      default:              load = 1'b0;
    endcase
  end

  // bound order, span level and start of the right block
  always_comb begin
    if (lo_index_i > hi_index_i) begin
      lo_s = hi_index_i;
      hi_s = lo_index_i;
    end else begin
      lo_s = lo_index_i;
      hi_s = hi_index_i;
    end
    len       = {1'b0, hi_s} - {1'b0, lo_s} + srmq_pkg::CNT_W'(1);
    lvl       = srmq_pkg::flog2(len);
    rpos_full = {1'b0, hi_s} + srmq_pkg::CNT_W'(1) - (srmq_pkg::CNT_W'(1) << lvl);
  end

  always_comb begin
    cmd_d = cmd_q;
    if (load) begin
      cmd_d.op   = srmq_pkg::kind_e'(kind_i);
      cmd_d.key  = key_value_i;
      cmd_d.tag  = tag_value_i;
      cmd_d.lo   = lo_s;
      cmd_d.hi   = hi_s;
      cmd_d.rpos = rpos_full[srmq_pkg::POS_W-1:0];
      cmd_d.lvl  = lvl;
    end
    valid_d = load || (valid_q && !cmd_push_o);
  end

  // staging register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

@@ rtl/core/srmq_fifo.sv @@
// ----------------------------------------------------------------------
// srmq_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------
module srmq_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  srmq_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output srmq_pkg::cmd_t pop_data_o,
  output logic           empty_o
);

  srmq_pkg::cmd_t               entry_q [srmq_pkg::QUEUE_DEPTH];
  logic [srmq_pkg::QPTR_W-1:0]  wr_ptr_q;
  logic [srmq_pkg::QPTR_W-1:0]  wr_ptr_d;
  logic [srmq_pkg::QPTR_W-1:0]  rd_ptr_q;
  logic [srmq_pkg::QPTR_W-1:0]  rd_ptr_d;
  logic [srmq_pkg::QCNT_W-1:0]  fill_q;
  logic [srmq_pkg::QCNT_W-1:0]  fill_d;
  logic                         do_push;
  logic                         do_pop;

  assign full_o     = (fill_q == srmq_pkg::QCNT_W'(srmq_pkg::QUEUE_DEPTH));
  assign empty_o    = (fill_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  // pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == srmq_pkg::QPTR_W'(srmq_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + srmq_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == srmq_pkg::QPTR_W'(srmq_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + srmq_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + srmq_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - srmq_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/srmq_back.sv @@
// ----------------------------------------------------------------------
// srmq_back
// Carries out clear, append and query commands against the element
// store and the sparse table, and holds the result register.
// ----------------------------------------------------------------------
module srmq_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  srmq_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [srmq_pkg::TAG_W-1:0]  min_tag_o,
  output logic [srmq_pkg::KEY_W-1:0]  min_key_o,
  output logic [srmq_pkg::POS_W-1:0]  min_position_o,
  output logic                        range_error_o
);

  srmq_pkg::back_state_e       state_q;
  srmq_pkg::back_state_e       state_d;
  srmq_pkg::cmd_t              cmd_q;
  srmq_pkg::cmd_t              cmd_d;
  logic [srmq_pkg::CNT_W-1:0]  count_q;
  logic [srmq_pkg::CNT_W-1:0]  count_d;
  logic [srmq_pkg::LVL_W-1:0]  nlev_q;
  logic [srmq_pkg::LVL_W-1:0]  nlev_d;
  logic [srmq_pkg::LVL_W-1:0]  iss_lvl_q;
  logic [srmq_pkg::LVL_W-1:0]  iss_lvl_d;

  // append pipeline: table read, key read, compare and write back
  logic                        p1_vld_q;
  logic                        p1_vld_d;
  logic [srmq_pkg::LVL_W-1:0]  p1_lvl_q;
  logic [srmq_pkg::LVL_W-1:0]  p1_lvl_d;
  logic [srmq_pkg::POS_W-1:0]  p1_s_q;
  logic [srmq_pkg::POS_W-1:0]  p1_s_d;
  logic                        p2_vld_q;
  logic                        p2_vld_d;
  logic [srmq_pkg::LVL_W-1:0]  p2_lvl_q;
  logic [srmq_pkg::LVL_W-1:0]  p2_lvl_d;
  logic [srmq_pkg::POS_W-1:0]  p2_s_q;
  logic [srmq_pkg::POS_W-1:0]  p2_s_d;
  logic [srmq_pkg::POS_W-1:0]  p2_pos_q;
  logic [srmq_pkg::POS_W-1:0]  p2_pos_d;
  logic [srmq_pkg::POS_W-1:0]  m_pos_q;
  logic [srmq_pkg::POS_W-1:0]  m_pos_d;
  logic [srmq_pkg::KEY_W-1:0]  m_key_q;
  logic [srmq_pkg::KEY_W-1:0]  m_key_d;

  // pending result and output register
  logic [srmq_pkg::TAG_W-1:0]  res_tag_q;
  logic [srmq_pkg::TAG_W-1:0]  res_tag_d;
  logic [srmq_pkg::KEY_W-1:0]  res_key_q;
  logic [srmq_pkg::KEY_W-1:0]  res_key_d;
  logic [srmq_pkg::POS_W-1:0]  res_pos_q;
  logic [srmq_pkg::POS_W-1:0]  res_pos_d;
  logic                        res_err_q;
  logic                        res_err_d;
  logic                        out_valid_q;
  logic                        out_valid_d;
  logic [srmq_pkg::TAG_W-1:0]  out_tag_q;
  logic [srmq_pkg::TAG_W-1:0]  out_tag_d;
  logic [srmq_pkg::KEY_W-1:0]  out_key_q;
  logic [srmq_pkg::KEY_W-1:0]  out_key_d;
  logic [srmq_pkg::POS_W-1:0]  out_pos_q;
  logic [srmq_pkg::POS_W-1:0]  out_pos_d;
  logic                        out_err_q;
  logic                        out_err_d;

  // memory ports
  logic                                 e_we;
  logic [srmq_pkg::POS_W-1:0]           e_raddr_a;
  logic [srmq_pkg::POS_W-1:0]           e_raddr_b;
  logic [srmq_pkg::ELEM_W-1:0]          e_rdata_a;
  logic [srmq_pkg::ELEM_W-1:0]          e_rdata_b;
  logic                                 t_we;
  logic [srmq_pkg::LVL_W+srmq_pkg::POS_W-1:0] t_waddr;
  logic [srmq_pkg::POS_W-1:0]           t_wdata;
  logic [srmq_pkg::LVL_W+srmq_pkg::POS_W-1:0] t_raddr_a;
  logic [srmq_pkg::LVL_W+srmq_pkg::POS_W-1:0] t_raddr_b;
  logic [srmq_pkg::POS_W-1:0]           t_rdata_a;
  logic [srmq_pkg::POS_W-1:0]           t_rdata_b;

  // derived conditions
  logic [srmq_pkg::CNT_W-1:0]  count_inc;
  logic [srmq_pkg::LVL_W-1:0]  nlev_new;
  logic                        store_full;
  logic                        query_oob;
  logic [srmq_pkg::CNT_W-1:0]  iss_s_full;
  logic [srmq_pkg::POS_W-1:0]  iss_s;
  logic [srmq_pkg::LVL_W-1:0]  iss_lvl_m1;
  logic                        iss_go;
  logic                        append_done;
  logic                        emit_ok;
  logic [srmq_pkg::KEY_W-1:0]  e_key_a;
  logic [srmq_pkg::TAG_W-1:0]  e_tag_a;
  logic [srmq_pkg::KEY_W-1:0]  e_key_b;
  logic [srmq_pkg::TAG_W-1:0]  e_tag_b;

  assign count_inc   = count_q + srmq_pkg::CNT_W'(1);
  assign nlev_new    = srmq_pkg::flog2(count_inc);
  assign store_full  = (count_q == srmq_pkg::CNT_W'(srmq_pkg::MAX_ELEMENTS));
  assign query_oob   = ({1'b0, cmd_q.hi} >= count_q);
  assign iss_s_full  = count_inc - (srmq_pkg::CNT_W'(1) << iss_lvl_q);
  assign iss_s       = iss_s_full[srmq_pkg::POS_W-1:0];
  assign iss_lvl_m1  = iss_lvl_q - srmq_pkg::LVL_W'(1);
  assign iss_go      = (iss_lvl_q <= nlev_q);
  assign append_done = p2_vld_q && (p2_lvl_q == nlev_q);
  assign emit_ok     = !out_valid_q || !out_stall_i;

  assign e_key_a = e_rdata_a[srmq_pkg::ELEM_W-1:srmq_pkg::TAG_W];
  assign e_tag_a = e_rdata_a[srmq_pkg::TAG_W-1:0];
  assign e_key_b = e_rdata_b[srmq_pkg::ELEM_W-1:srmq_pkg::TAG_W];
  assign e_tag_b = e_rdata_b[srmq_pkg::TAG_W-1:0];

  // element store, key in the upper half
  srmq_ram #(
    .WIDTH (srmq_pkg::ELEM_W),
    .DEPTH (srmq_pkg::MAX_ELEMENTS)
  ) u_elem_ram (
    .clk_i     (clk_i),
    .we_i      (e_we),
    .waddr_i   (count_q[srmq_pkg::POS_W-1:0]),
    .wdata_i   ({cmd_q.key, cmd_q.tag}),
    .raddr_a_i (e_raddr_a),
    .raddr_b_i (e_raddr_b),
    .rdata_a_o (e_rdata_a),
    .rdata_b_o (e_rdata_b)
  );

  // sparse table, level in the upper address bits
  srmq_ram #(
    .WIDTH (srmq_pkg::POS_W),
    .DEPTH (srmq_pkg::TBL_DEPTH)
  ) u_tbl_ram (
    .clk_i     (clk_i),
    .we_i      (t_we),
    .waddr_i   (t_waddr),
    .wdata_i   (t_wdata),
    .raddr_a_i (t_raddr_a),
    .raddr_b_i (t_raddr_b),
    .rdata_a_o (t_rdata_a),
    .rdata_b_o (t_rdata_b)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srmq_pkg::ST_IDLE: begin
        if (cmd_valid_i) state_d = srmq_pkg::ST_START;
      end
      srmq_pkg::ST_START: begin
        unique case (cmd_q.op)
          srmq_pkg::KIND_CLEAR: state_d = srmq_pkg::ST_IDLE;
          srmq_pkg::KIND_APPEND: begin
            if (store_full || nlev_new == '0) begin
              state_d = srmq_pkg::ST_EMIT;
            end else begin
              state_d = srmq_pkg::ST_APPEND;
            end
          end
          srmq_pkg::KIND_QUERY: begin
            state_d = query_oob ? srmq_pkg::ST_EMIT : srmq_pkg::ST_Q_KEY;
          end
          default: state_d = srmq_pkg::ST_IDLE;
        endcase
      end
      srmq_pkg::ST_APPEND: begin
        if (append_done) state_d = srmq_pkg::ST_EMIT;
      end
      srmq_pkg::ST_Q_KEY:  state_d = srmq_pkg::ST_Q_PICK;
      srmq_pkg::ST_Q_PICK: state_d = srmq_pkg::ST_EMIT;
      srmq_pkg::ST_EMIT: begin
        if (emit_ok) state_d = srmq_pkg::ST_IDLE;
      end
      default: state_d = srmq_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control per state
  always_comb begin
    cmd_pop_o   = 1'b0;
    cmd_d       = cmd_q;
    count_d     = count_q;
    nlev_d      = nlev_q;
    iss_lvl_d   = iss_lvl_q;
    p1_vld_d    = 1'b0;
    p1_lvl_d    = p1_lvl_q;
    p1_s_d      = p1_s_q;
    p2_vld_d    = 1'b0;
    p2_lvl_d    = p2_lvl_q;
    p2_s_d      = p2_s_q;
    p2_pos_d    = p2_pos_q;
    m_pos_d     = m_pos_q;
    m_key_d     = m_key_q;
    res_tag_d   = res_tag_q;
    res_key_d   = res_key_q;
    res_pos_d   = res_pos_q;
    res_err_d   = res_err_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_tag_d   = out_tag_q;
    out_key_d   = out_key_q;
    out_pos_d   = out_pos_q;
    out_err_d   = out_err_q;
    e_we        = 1'b0;
    e_raddr_a   = '0;
    e_raddr_b   = '0;
    t_we        = 1'b0;
    t_waddr     = '0;
    t_wdata     = '0;
    t_raddr_a   = '0;
    t_raddr_b   = '0;

    unique case (state_q)
      srmq_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
        end
      end

      srmq_pkg::ST_START: begin
        res_tag_d = '0;
        res_key_d = '0;
        res_pos_d = '0;
        res_err_d = 1'b0;
        unique case (cmd_q.op)
          srmq_pkg::KIND_CLEAR: count_d = '0;
          srmq_pkg::KIND_APPEND: begin
            if (store_full) begin
              res_err_d = 1'b1;
            end else begin
              // store the element and its single-element block
              e_we      = 1'b1;
              t_we      = 1'b1;
              t_waddr   = {srmq_pkg::LVL_W'(0), count_q[srmq_pkg::POS_W-1:0]};
              t_wdata   = count_q[srmq_pkg::POS_W-1:0];
              m_pos_d   = count_q[srmq_pkg::POS_W-1:0];
              m_key_d   = cmd_q.key;
              nlev_d    = nlev_new;
              iss_lvl_d = srmq_pkg::LVL_W'(1);
              if (nlev_new == '0) count_d = count_inc;
            end
          end
          srmq_pkg::KIND_QUERY: begin
            if (query_oob) begin
              res_err_d = 1'b1;
            end else begin
              t_raddr_a = {cmd_q.lvl, cmd_q.lo};
              t_raddr_b = {cmd_q.lvl, cmd_q.rpos};
            end
          end
          default: ;
        endcase
      end

      srmq_pkg::ST_APPEND: begin
        // issue the left half of the next level
        if (iss_go) begin
          t_raddr_a = {iss_lvl_m1, iss_s};
          p1_vld_d  = 1'b1;
          p1_lvl_d  = iss_lvl_q;
          p1_s_d    = iss_s;
          iss_lvl_d = iss_lvl_q + srmq_pkg::LVL_W'(1);
        end
        // fetch the key of the left minimum
        if (p1_vld_q) begin
          e_raddr_a = t_rdata_a;
          p2_vld_d  = 1'b1;
          p2_lvl_d  = p1_lvl_q;
          p2_s_d    = p1_s_q;
          p2_pos_d  = t_rdata_a;
        end
        // merge with the running right minimum, left wins ties
        if (p2_vld_q) begin
          if (!(e_key_a > m_key_q)) begin
            m_pos_d = p2_pos_q;
            m_key_d = e_key_a;
          end
          t_we    = 1'b1;
          t_waddr = {p2_lvl_q, p2_s_q};
          t_wdata = (e_key_a > m_key_q) ? m_pos_q : p2_pos_q;
          if (append_done) count_d = count_inc;
        end
      end

      srmq_pkg::ST_Q_KEY: begin
        e_raddr_a = t_rdata_a;
        e_raddr_b = t_rdata_b;
        p2_pos_d  = t_rdata_a;
        m_pos_d   = t_rdata_b;
      end

      srmq_pkg::ST_Q_PICK: begin
        if (e_key_a > e_key_b) begin
          res_tag_d = e_tag_b;
          res_key_d = e_key_b;
          res_pos_d = m_pos_q;
        end else begin
          res_tag_d = e_tag_a;
          res_key_d = e_key_a;
          res_pos_d = p2_pos_q;
        end
        res_err_d = 1'b0;
      end

      srmq_pkg::ST_EMIT: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_tag_d   = res_tag_q;
          out_key_d   = res_key_q;
          out_pos_d   = res_pos_q;
          out_err_d   = res_err_q;
        end
      end

      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srmq_pkg::ST_IDLE;
      count_q     <= '0;
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      p1_vld_q    <= p1_vld_d;
      p2_vld_q    <= p2_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    nlev_q    <= nlev_d;
    iss_lvl_q <= iss_lvl_d;
    p1_lvl_q  <= p1_lvl_d;
    p1_s_q    <= p1_s_d;
    p2_lvl_q  <= p2_lvl_d;
    p2_s_q    <= p2_s_d;
    p2_pos_q  <= p2_pos_d;
    m_pos_q   <= m_pos_d;
    m_key_q   <= m_key_d;
    res_tag_q <= res_tag_d;
    res_key_q <= res_key_d;
    res_pos_q <= res_pos_d;
    res_err_q <= res_err_d;
    out_tag_q <= out_tag_d;
    out_key_q <= out_key_d;
    out_pos_q <= out_pos_d;
    out_err_q <= out_err_d;
  end

  assign out_valid_o    = out_valid_q;
  assign min_tag_o      = out_tag_q;
  assign min_key_o      = out_key_q;
  assign min_position_o = out_pos_q;
  assign range_error_o  = out_err_q;

endmodule

@@ rtl/core/sparse_table_range_min_query.sv @@
// ----------------------------------------------------------------------
// sparse_table_range_min_query
// Range-minimum query over an append-only array of (key, tag) elements.
// ----------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes clear, append and query
// items; kind 3 is taken and ignored. Output channel (out_valid_o /
// out_stall_i) gives one result per append and per query, none for clear.
// Items are handled one at a time by a sequencer that reads a dual-read
// element RAM and a dual-read sparse-table RAM; the table holds, per
// level, the position of the leftmost minimum of each power-of-two block.
// An append fills table level 0 and then levels 1 to L, where
// L = floor(log2(count + 1)), at most 10, one table level per cycle
// through a three-stage read-read-merge pipeline. An append of the first
// element fills level 0 only; an append into a full store writes nothing.
// A two-entry command queue sits between the accept stage and the
// sequencer, so new items are taken while a result waits in the output
// register. When out_stall_i is high the result holds and the block stops
// taking items once the queue fills.
// Reset empties the store (count zero) and the queue; the RAMs need no
// clearing pass.
// ----------------------------------------------------------------------
module sparse_table_range_min_query (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic [srmq_pkg::KEY_W-1:0]  key_value_i,
  input  logic [srmq_pkg::TAG_W-1:0]  tag_value_i,
  input  logic [srmq_pkg::POS_W-1:0]  lo_index_i,
  input  logic [srmq_pkg::POS_W-1:0]  hi_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [srmq_pkg::TAG_W-1:0]  min_tag_o,
  output logic [srmq_pkg::KEY_W-1:0]  min_key_o,
  output logic [srmq_pkg::POS_W-1:0]  min_position_o,
  output logic                        range_error_o
);

  logic           push;
  logic           full;
  logic           pop;
  logic           empty;
  srmq_pkg::cmd_t front_cmd;
  srmq_pkg::cmd_t head_cmd;

  // accept and classify
  srmq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .key_value_i (key_value_i),
    .tag_value_i (tag_value_i),
    .lo_index_i  (lo_index_i),
    .hi_index_i  (hi_index_i),
    .cmd_push_o  (push),
    .cmd_o       (front_cmd),
    .cmd_full_i  (full)
  );

  // command queue
  srmq_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head_cmd),
    .empty_o     (empty)
  );

  // execute and deliver
  srmq_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (!empty),
    .cmd_i          (head_cmd),
    .cmd_pop_o      (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .min_tag_o      (min_tag_o),
    .min_key_o      (min_key_o),
    .min_position_o (min_position_o),
    .range_error_o  (range_error_o)
  );

endmodule

@@ rtl/core/srmq_checker.sv @@
// ----------------------------------------------------------------------
// srmq_checker
// Port-level checks of the range-minimum block, bound to the top level.
// ----------------------------------------------------------------------
`include "assert_macros.svh"

module srmq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [srmq_pkg::TAG_W-1:0]  min_tag_o,
  input logic [srmq_pkg::KEY_W-1:0]  min_key_o,
  input logic [srmq_pkg::POS_W-1:0]  min_position_o,
  input logic                        range_error_o
);

  // a stalled result stays offered
  `SRMQ_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")

  // a stalled result keeps its fields
  `SRMQ_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(min_tag_o) && $stable(min_key_o) && $stable(min_position_o) && $stable(range_error_o), "result changed while stalled")

  // error results carry an all-zero payload
  `SRMQ_ASSERT(a_err_zero, clk_i, rst_ni, out_valid_o && range_error_o |-> min_tag_o == '0 && min_key_o == '0 && min_position_o == '0, "error result with nonzero payload")

  // nothing is offered in the cycle after reset is seen
  `SRMQ_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind sparse_table_range_min_query srmq_checker u_srmq_checker (.*);

@@ tb/sv/tb_sparse_table_range_min_query.sv @@
// ----------------------------------------------------------------------
// tb_sparse_table_range_min_query
// Self-checking bench for the range-minimum query block: a short table of
// directed items, then random clear / append / query traffic under three
// idle profiles and a receiver hold-off. Every result is checked against
// a typed-in expected value or a behavioral model of the store.
// ----------------------------------------------------------------------
module tb_sparse_table_range_min_query;
  timeunit 1ns;
  timeprecision 1ps;

  // kind code that the block takes and ignores
  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         NUM_DIRECTED = 23;
  localparam int         QUIET_LIMIT  = 4000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         TAIL_CYCLES  = 40;

  // one result item
  typedef struct packed {
    logic [srmq_pkg::TAG_W-1:0] min_tag;
    logic [srmq_pkg::KEY_W-1:0] min_key;
    logic [srmq_pkg::POS_W-1:0] min_pos;
    logic                       range_err;
  } minimum_t;

  // one input item, with an optional typed-in expected result
  typedef struct packed {
    logic [1:0]                 kind;
    logic [srmq_pkg::KEY_W-1:0] key;
    logic [srmq_pkg::TAG_W-1:0] tag;
    logic [srmq_pkg::POS_W-1:0] lo;
    logic [srmq_pkg::POS_W-1:0] hi;
    logic                       typed;
    minimum_t                   want;
  } stim_row_t;

  localparam minimum_t APPEND_OK = '{min_tag: '0, min_key: '0, min_pos: '0, range_err: 1'b0};
  localparam minimum_t RANGE_ERR = '{min_tag: '0, min_key: '0, min_pos: '0, range_err: 1'b1};

  logic                       clk_i       = 1'b0;
  logic                       rst_n_r     = 1'b0;
  logic                       in_valid_r  = 1'b0;
  logic [1:0]                 kind_r      = '0;
  logic [srmq_pkg::KEY_W-1:0] key_r       = '0;
  logic [srmq_pkg::TAG_W-1:0] tag_r       = '0;
  logic [srmq_pkg::POS_W-1:0] lo_r        = '0;
  logic [srmq_pkg::POS_W-1:0] hi_r        = '0;
  logic                       out_stall_r = 1'b0;

  logic                       in_stall_o;
  logic                       out_valid_o;
  logic [srmq_pkg::TAG_W-1:0] min_tag_o;
  logic [srmq_pkg::KEY_W-1:0] min_key_o;
  logic [srmq_pkg::POS_W-1:0] min_position_o;
  logic                       range_error_o;

  // model of the store
  logic [srmq_pkg::KEY_W-1:0] held_keys [srmq_pkg::MAX_ELEMENTS];
  logic [srmq_pkg::TAG_W-1:0] held_tags [srmq_pkg::MAX_ELEMENTS];
  int unsigned                held_count = 0;

  minimum_t    awaited_minima [$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned hold_requests  = 0;

  sparse_table_range_min_query u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n_r),
    .in_valid_i     (in_valid_r),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_r),
    .key_value_i    (key_r),
    .tag_value_i    (tag_r),
    .lo_index_i     (lo_r),
    .hi_index_i     (hi_r),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_r),
    .min_tag_o      (min_tag_o),
    .min_key_o      (min_key_o),
    .min_position_o (min_position_o),
    .range_error_o  (range_error_o)
  );

  // directed items: extremes, ties, swapped bounds, out-of-range, clear, unused kind
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{srmq_pkg::KIND_QUERY,  16'h0000, 16'h0000, 10'd0,    10'd0,    1'b1, RANGE_ERR},
    '{srmq_pkg::KIND_QUERY,  16'h0000, 16'h0000, 10'd1023, 10'd1023, 1'b1, RANGE_ERR},
    '{srmq_pkg::KIND_QUERY,  16'h0000, 16'h0000, 10'd1023, 10'd0,    1'b1, RANGE_ERR},
    '{srmq_pkg::KIND_APPEND, 16'hFFFF, 16'h0000, 10'd0,    10'd0,    1'b1, APPEND_OK},
    '{srmq_pkg::KIND_APPEND, 16'h0000, 16'hFFFF, 10'd0,    10'd0,    1'b1, APPEND_OK},
    '{srmq_pkg::KIND_APPEND, 16'h8000, 16'h1234, 10'd0,    10'd0,    1'b1, APPEND_OK},
    '{srmq_pkg::KIND_APPEND, 16'h0000, 16'hAAAA, 10'd0,    10'd0,    1'b1, APPEND_OK},
    '{srmq_pkg::KIND_QUERY,  16'h0000, 16'h0000, 10'd0,    10'd0,    1'b1,
      '{min_tag: 16'h0000, min_key: 16'hFFFF, min_pos: 10'd0, range_err: 1'b0}},
    '{srmq_pkg::KIND_QUERY,  16'h0000, 16'h0000, 10'd0,    10'd3,    1'b0, APPEND_OK},
    '{srmq_pkg::KIND_QUERY,  16'h0000, 16'h0000, 10'd3,    10'd0,    1'b0, APPEND_OK},
    '{srmq_pkg::KIND_QUERY,  16'h0000, 16'h0000, 10'd2,    10'd3,    1'b0, APPEND_OK},
    '{srmq_pkg::KIND_QUERY,  16'h0000, 16'h0000, 10'd0,    10'd4,    1'b1, RANGE_ERR},
    '{srmq_pkg::KIND_QUERY,  16'h0000, 16'h0000, 10'd4,    10'd1,    1'b1, RANGE_ERR},
    '{KIND_UNUSED,           16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023, 1'b0, APPEND_OK},
    '{srmq_pkg::KIND_QUERY,  16'h0000, 16'h0000, 10'd1,    10'd1,    1'b0, APPEND_OK},
    '{srmq_pkg::KIND_CLEAR,  16'h0000, 16'h0000, 10'd0,    10'd0,    1'b0, APPEND_OK},
    '{srmq_pkg::KIND_QUERY,  16'h0000, 16'h0000, 10'd0,    10'd0,    1'b1, RANGE_ERR},
    '{srmq_pkg::KIND_APPEND, 16'h0005, 16'h0007, 10'd0,    10'd0,    1'b1, APPEND_OK},
    '{srmq_pkg::KIND_QUERY,  16'h0000, 16'h0000, 10'd0,    10'd0,    1'b0, APPEND_OK},
    '{srmq_pkg::KIND_QUERY,  16'h0000, 16'h0000, 10'd0,    10'd1023, 1'b1, RANGE_ERR},
    '{KIND_UNUSED,           16'h0000, 16'h0000, 10'd0,    10'd0,    1'b0, APPEND_OK},
    '{srmq_pkg::KIND_APPEND, 16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023, 1'b1, APPEND_OK},
    '{srmq_pkg::KIND_QUERY,  16'h0000, 16'h0000, 10'd1,    10'd0,    1'b0, APPEND_OK}
  };

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // update the model store and work out the result of one item
  function automatic bit predict_minimum(input stim_row_t row, output minimum_t res);
    logic [srmq_pkg::POS_W-1:0] lo;
    logic [srmq_pkg::POS_W-1:0] hi;
    logic [srmq_pkg::POS_W-1:0] swap;
    logic [srmq_pkg::POS_W-1:0] best;
    int unsigned                p;
    res = '0;
    case (row.kind)
      srmq_pkg::KIND_CLEAR: begin
        held_count = 0;
        return 1'b0;
      end
      srmq_pkg::KIND_APPEND: begin
        if (held_count >= srmq_pkg::MAX_ELEMENTS) begin
          res.range_err = 1'b1;
        end else begin
          held_keys[held_count] = row.key;
          held_tags[held_count] = row.tag;
          held_count++;
        end
        return 1'b1;
      end
      srmq_pkg::KIND_QUERY: begin
        lo = row.lo;
        hi = row.hi;
        if (lo > hi) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
        if (hi >= held_count) begin
          res.range_err = 1'b1;
          return 1'b1;
        end
        // leftmost smallest key wins
        best = lo;
        for (p = lo + 1; p <= hi; p++) begin
          if (held_keys[p] < held_keys[best]) best = srmq_pkg::POS_W'(p);
        end
        res.min_tag = held_tags[best];
        res.min_key = held_keys[best];
        res.min_pos = best;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // random item, mostly queries, most of which stay inside the stored range
  function automatic stim_row_t draw_random_item();
    stim_row_t                  row;
    int unsigned                pick;
    logic [srmq_pkg::POS_W-1:0] swap;
    row      = '0;
    row.key  = srmq_pkg::KEY_W'($urandom);
    row.tag  = srmq_pkg::TAG_W'($urandom);
    row.lo   = srmq_pkg::POS_W'($urandom);
    row.hi   = srmq_pkg::POS_W'($urandom);
    pick     = $urandom_range(0, 99);
    if (pick < 2) begin
      row.kind = srmq_pkg::KIND_CLEAR;
    end else if (pick < 5) begin
      row.kind = KIND_UNUSED;
    end else if (pick < 45) begin
      row.kind = srmq_pkg::KIND_APPEND;
      // small keys give plenty of ties
      if ($urandom_range(0, 1) != 0) row.key = srmq_pkg::KEY_W'($urandom_range(0, 15));
    end else begin
      row.kind = srmq_pkg::KIND_QUERY;
      if (pick >= 55 && held_count != 0) begin
        row.hi = srmq_pkg::POS_W'($urandom_range(0, held_count - 1));
        row.lo = srmq_pkg::POS_W'($urandom_range(0, row.hi));
        if ($urandom_range(0, 9) == 0) begin
          row.lo = '0;
          row.hi = srmq_pkg::POS_W'(held_count - 1);
        end
        if ($urandom_range(0, 2) == 0) begin
          swap   = row.lo;
          row.lo = row.hi;
          row.hi = swap;
        end
      end
    end
    return row;
  endfunction

  task automatic flag_mismatch(input string field, input int unsigned got,
                               input int unsigned want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
    mismatch_count++;
  endtask

  // present one item, hold it until taken, then record its expected result
  task automatic offer_item(input stim_row_t row);
    minimum_t predicted;
    minimum_t expected;
    bit       emits;
    bit       taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_r <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_r <= 1'b1;
    kind_r     <= row.kind;
    key_r      <= row.key;
    tag_r      <= row.tag;
    lo_r       <= row.lo;
    hi_r       <= row.hi;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    emits = predict_minimum(row, predicted);
    expected = row.typed ? row.want : predicted;
    if (emits) awaited_minima = {awaited_minima, expected};
  endtask

  task automatic run_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) offer_item(draw_random_item());
  endtask

  // stop sending and wait for every outstanding result
  task automatic pause_until_drained();
    in_valid_r <= 1'b0;
    @(posedge clk_i);
    while (awaited_minima.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall, with a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_r <= 1'b1;
      end else begin
        out_stall_r <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // result check and activity count, sampled mid-cycle
  always @(negedge clk_i) begin
    minimum_t want;
    if (rst_n_r && ((in_valid_r && !in_stall_o) || (out_valid_o && !out_stall_r)))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (rst_n_r && out_valid_o && !out_stall_r) begin
      if (awaited_minima.size() == 0) begin
        flag_mismatch("unexpected result", 0, 0);
      end else begin
        want = awaited_minima.pop_front();
        if (min_tag_o != want.min_tag) flag_mismatch("min_tag", min_tag_o, want.min_tag);
        if (min_key_o != want.min_key) flag_mismatch("min_key", min_key_o, want.min_key);
        if (min_position_o != want.min_pos)
          flag_mismatch("min_position", min_position_o, want.min_pos);
        if (range_error_o != want.range_err)
          flag_mismatch("range_error", range_error_o, want.range_err);
      end
    end
  end

  // watchdog on cycles with no accepted item and no taken result
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // stimulus
  initial begin
    repeat (8) @(posedge clk_i);
    rst_n_r <= 1'b1;

    // sender rarely idle, receiver mostly stalled
    send_idle_pct = 14;
    recv_idle_pct = 71;
    for (int i = 0; i < NUM_DIRECTED; i++) offer_item(directed_rows[i]);
    pause_until_drained();
    run_random(120);
    // long receiver hold-off while items keep coming
    hold_requests++;
    run_random(15);
    run_random(100);
    pause_until_drained();

    // sender mostly idle, receiver rarely stalled
    send_idle_pct = 71;
    recv_idle_pct = 14;
    run_random(250);
    pause_until_drained();

    // no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(100);
    offer_item(stim_row_t'{srmq_pkg::KIND_QUERY, 16'h0, 16'h0, 10'd0,    10'd1023, 1'b0,
                           APPEND_OK});
    offer_item(stim_row_t'{srmq_pkg::KIND_QUERY, 16'h0, 16'h0, 10'd1023, 10'd1023, 1'b0,
                           APPEND_OK});
    offer_item(stim_row_t'{srmq_pkg::KIND_QUERY, 16'h0, 16'h0, 10'd1023, 10'd0,    1'b0,
                           APPEND_OK});
    offer_item(stim_row_t'{srmq_pkg::KIND_QUERY, 16'h0, 16'h0, 10'd511,  10'd512,  1'b0,
                           APPEND_OK});
    run_random(150);

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
